FILE: hdl/quaternion_vector_rotate_macros.svh
// ----------------------------------------------------------------------------
// quaternion_vector_rotate assertion macros
// Shared concurrent assertion shorthands; clk and rst_n come from the user.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

// same-cycle implication, ignored while reset is low
`define QVR_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qvr: implication check failed");

// consequent must hold after the antecedent, with the delay given by n
`define QVR_ASSERT_DELAYED(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("qvr: delayed check failed");

`endif

FILE: hdl/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Default widths for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QUAT_WIDTH = 18;  // quaternion component, QUAT_WIDTH-2 fraction bits
  localparam int VEC_WIDTH  = 24;  // vector component, 12 fraction bits

  localparam int PIPE_DEPTH = 6;   // register stages from accept to result

endpackage

FILE: hdl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a 3-vector by a quaternion: vector part of q * (0,v) * conj(q).
// ----------------------------------------------------------------------------
// Fully pipelined, one beat per clock: busy is tied low and a new quaternion
// and vector may be presented with start in every cycle. Each result passes
// through the stages s1 to s6 listed below, with out_valid high for a single
// cycle; the receiver cannot hold it off, so it must take every strobe.
// Results leave in input order. No conjugate-to-inverse normalisation is
// done: a non-unit quaternion scales the output by its squared norm. The
// exact sum is rounded half up and saturated, and out_saturated flags a
// clipped component. There is no configuration and no state between beats.
//
// Pipeline:
//   s1  ten quadratic products of the quaternion components (18x18)
//   s2  rotation matrix M = N^2 * R, nine exact entries of 2*QW+2 bits
//   s3  each M entry times a vector component, as two half-width partials
//   s4  partials recombined into exact products
//   s5  three products per row plus the rounding half
//   s6  shift, saturate, output register
// The critical path is one s3 partial multiply (about 20x24 at the defaults).
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
  parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH,
  parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_w,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_x,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_y,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_z,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_z,
  // result side
  output logic                         out_valid,
  output logic signed [VEC_WIDTH-1:0]  out_rot_x,
  output logic signed [VEC_WIDTH-1:0]  out_rot_y,
  output logic signed [VEC_WIDTH-1:0]  out_rot_z,
  output logic                         out_saturated
);

  `include "quaternion_vector_rotate_macros.svh"

  // widths
  localparam int QP  = 2 * QUAT_WIDTH;        // quadratic product
  localparam int MW  = QP + 2;                // matrix entry, exact
  localparam int LW  = MW / 2;                // low partial width (unsigned)
  localparam int HW  = MW - LW;               // high partial width (signed)
  localparam int PW  = MW + VEC_WIDTH;        // exact product
  localparam int SW  = PW + 3;                // row sum incl. rounding half
  localparam int SH  = 2 * (QUAT_WIDTH - 2);  // fraction bits dropped
  localparam int LAT = qvr_pkg::PIPE_DEPTH;

  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  logic accept;
  logic [LAT-1:0] valid_r, valid_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign valid_nxt = {valid_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // ---- s1: quadratic products ----------------------------------------------
  // index: 0 ww, 1 xx, 2 yy, 3 zz, 4 xy, 5 xz, 6 yz, 7 wx, 8 wy, 9 wz
  logic signed [QP-1:0]        sq_r   [10];
  logic signed [QP-1:0]        sq_nxt [10];
  logic signed [VEC_WIDTH-1:0] v1_r   [3];

  always_comb begin
    sq_nxt[0] = QP'(in_quat_w) * QP'(in_quat_w);
    sq_nxt[1] = QP'(in_quat_x) * QP'(in_quat_x);
    sq_nxt[2] = QP'(in_quat_y) * QP'(in_quat_y);
    sq_nxt[3] = QP'(in_quat_z) * QP'(in_quat_z);
    sq_nxt[4] = QP'(in_quat_x) * QP'(in_quat_y);
    sq_nxt[5] = QP'(in_quat_x) * QP'(in_quat_z);
    sq_nxt[6] = QP'(in_quat_y) * QP'(in_quat_z);
    sq_nxt[7] = QP'(in_quat_w) * QP'(in_quat_x);
    sq_nxt[8] = QP'(in_quat_w) * QP'(in_quat_y);
    sq_nxt[9] = QP'(in_quat_w) * QP'(in_quat_z);
  end

  always_ff @(posedge clk) begin
    sq_r  <= sq_nxt;
    v1_r[0] <= in_vec_x;
    v1_r[1] <= in_vec_y;
    v1_r[2] <= in_vec_z;
  end

  // ---- s2: scaled rotation matrix, row-major -------------------------------
  logic signed [MW-1:0]        m_r   [9];
  logic signed [MW-1:0]        m_nxt [9];
  logic signed [VEC_WIDTH-1:0] v2_r  [3];

  always_comb begin
    m_nxt[0] = MW'(sq_r[0]) + MW'(sq_r[1]) - MW'(sq_r[2]) - MW'(sq_r[3]);
    m_nxt[1] = (MW'(sq_r[4]) - MW'(sq_r[9])) <<< 1;
    m_nxt[2] = (MW'(sq_r[5]) + MW'(sq_r[8])) <<< 1;
    m_nxt[3] = (MW'(sq_r[4]) + MW'(sq_r[9])) <<< 1;
    m_nxt[4] = MW'(sq_r[0]) - MW'(sq_r[1]) + MW'(sq_r[2]) - MW'(sq_r[3]);
    m_nxt[5] = (MW'(sq_r[6]) - MW'(sq_r[7])) <<< 1;
    m_nxt[6] = (MW'(sq_r[5]) - MW'(sq_r[8])) <<< 1;
    m_nxt[7] = (MW'(sq_r[6]) + MW'(sq_r[7])) <<< 1;
    m_nxt[8] = MW'(sq_r[0]) - MW'(sq_r[1]) - MW'(sq_r[2]) + MW'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    m_r  <= m_nxt;
    v2_r <= v1_r;
  end

  // ---- s3: split multiplies ------------------------------------------------
  // M = Mh * 2^LW + Ml, Ml taken as unsigned
  logic signed [LW+VEC_WIDTH:0]   pl_r   [9];
  logic signed [LW+VEC_WIDTH:0]   pl_nxt [9];
  logic signed [HW+VEC_WIDTH-1:0] ph_r   [9];
  logic signed [HW+VEC_WIDTH-1:0] ph_nxt [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pl_nxt[i] = (LW+VEC_WIDTH+1)'($signed({1'b0, m_r[i][LW-1:0]}))
                * (LW+VEC_WIDTH+1)'(v2_r[i % 3]);
      ph_nxt[i] = (HW+VEC_WIDTH)'($signed(m_r[i][MW-1:LW]))
                * (HW+VEC_WIDTH)'(v2_r[i % 3]);
    end
  end

  always_ff @(posedge clk) begin
    pl_r <= pl_nxt;
    ph_r <= ph_nxt;
  end

  // ---- s4: recombine partials ----------------------------------------------
  logic signed [PW-1:0] p_r   [9];
  logic signed [PW-1:0] p_nxt [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p_nxt[i] = (PW'(ph_r[i]) <<< LW) + PW'(pl_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  // ---- s5: row sums plus rounding half -------------------------------------
  logic signed [SW-1:0] sum_r   [3];
  logic signed [SW-1:0] sum_nxt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = SW'(p_r[3*r]) + SW'(p_r[3*r+1]) + SW'(p_r[3*r+2]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // ---- s6: drop fraction, saturate -----------------------------------------
  logic signed [VEC_WIDTH-1:0] rot_nxt [3];
  logic [2:0]                  clip;
  logic signed [VEC_WIDTH-1:0] out_rot_x_r, out_rot_y_r, out_rot_z_r;
  logic                        out_saturated_r, out_saturated_nxt;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      // in range when the bits above the result all match its sign
      clip[r] = ~((&sum_r[r][SW-1:SH+VEC_WIDTH-1]) | ~(|sum_r[r][SW-1:SH+VEC_WIDTH-1]));
      if (clip[r]) begin
        rot_nxt[r] = sum_r[r][SW-1] ? VMIN : VMAX;
      end else begin
        rot_nxt[r] = sum_r[r][SH+VEC_WIDTH-1:SH];
      end
    end
    out_saturated_nxt = |clip;
  end

  always_ff @(posedge clk) begin
    out_rot_x_r     <= rot_nxt[0];
    out_rot_y_r     <= rot_nxt[1];
    out_rot_z_r     <= rot_nxt[2];
    out_saturated_r <= out_saturated_nxt;
  end

  assign out_valid     = valid_r[LAT-1];
  assign out_rot_x     = out_rot_x_r;
  assign out_rot_y     = out_rot_y_r;
  assign out_rot_z     = out_rot_z_r;
  assign out_saturated = out_saturated_r;

  // ---- checks --------------------------------------------------------------
  `QVR_ASSERT_DELAYED(a_start_gives_result, accept, 6, out_valid)
  `QVR_ASSERT_IMPLIES(a_result_has_start, out_valid, $past(accept, LAT))
  `QVR_ASSERT_IMPLIES(a_sat_hits_bound, out_valid && out_saturated,
    out_rot_x == VMAX || out_rot_x == VMIN || out_rot_y == VMAX ||
    out_rot_y == VMIN || out_rot_z == VMAX || out_rot_z == VMIN)

endmodule
